// ----- src/yhr_pkg.sv -----
// Shared constants and helpers for the YIQ hue rotation pixel pipeline.
`timescale 1ns / 1ps

package yhr_pkg;

	// Register indexes of the configuration port.
	localparam logic REG_COS_ANGLE = 1'b0;
	localparam logic REG_SIN_ANGLE = 1'b1;

	// Fixed width of the angle registers and of their fractional part.
	localparam int ANGLE_W    = 16;
	localparam int ANGLE_FRAC = 14;
	localparam int CHAN_W     = 8;

	// Matrix entries in thousandths, row by row.
	localparam int YIQ_MILLI [9] = '{
		299,  587,  114,
		596, -274, -321,
		211, -523,  311
	};

	localparam int RGB_MILLI [9] = '{
		1000,   956,  621,
		1000,  -272, -647,
		1000, -1107, 1705
	};

	// Converts thousandths into a fixed-point value with the given fractional
	// bits, rounding ties away from zero.
	function automatic longint coef_q(input int milli, input int frac);
		longint scale;
		longint mag;
		scale = longint'(1) << frac;
		if (milli >= 0) begin
			mag = (longint'(milli) * scale + 500) / 1000;
			return mag;
		end else begin
			mag = (longint'(-milli) * scale + 500) / 1000;
			return -mag;
		end
	endfunction

endpackage

// ----- src/yiq_hue_rotate_pixel.sv -----
// Five-stage pipeline that rotates the hue of one RGB pixel in the YIQ plane.
`timescale 1ns / 1ps

// The block takes one pixel per beat and returns one pixel per beat, with a
// sustained rate of one pixel per clock while the output side accepts beats.
// The five pipeline stages are the RGB to YIQ sums, the four products of the
// I/Q rotation, the rotation sums, the YIQ to RGB products and finally the
// sums with clamping into the output register. Each stage holds its own valid
// bit and only stalls when the stage after it is full and stalled, so bubbles
// are squeezed out. The angle registers should be written only while no pixel
// is in flight.
module yiq_hue_rotate_pixel #(
	parameter int FRAC_BITS = 14
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [23:0]                  s_axis_tdata,  // red_in, green_in, blue_in
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [23:0]                  m_axis_tdata,  // red_out, green_out, blue_out
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [yhr_pkg::ANGLE_W-1:0]  cfg_data
);
	import yhr_pkg::*;

	localparam int CW = FRAC_BITS + 3;          // matrix coefficient
	localparam int YW = FRAC_BITS + 10;         // Y, I and Q
	localparam int PW = FRAC_BITS + 26;         // rotation products and sums
	localparam int RW = PW - ANGLE_FRAC;        // rotated I and Q
	localparam int SW = 2 * FRAC_BITS + 16;     // back conversion products and sums
	localparam int TW = SW - 2 * FRAC_BITS;     // floored channel value

	localparam logic signed [CW-1:0] K_YIQ [9] = '{
		CW'(coef_q(YIQ_MILLI[0], FRAC_BITS)), CW'(coef_q(YIQ_MILLI[1], FRAC_BITS)),
		CW'(coef_q(YIQ_MILLI[2], FRAC_BITS)), CW'(coef_q(YIQ_MILLI[3], FRAC_BITS)),
		CW'(coef_q(YIQ_MILLI[4], FRAC_BITS)), CW'(coef_q(YIQ_MILLI[5], FRAC_BITS)),
		CW'(coef_q(YIQ_MILLI[6], FRAC_BITS)), CW'(coef_q(YIQ_MILLI[7], FRAC_BITS)),
		CW'(coef_q(YIQ_MILLI[8], FRAC_BITS))
	};

	localparam logic signed [CW-1:0] K_RGB [9] = '{
		CW'(coef_q(RGB_MILLI[0], FRAC_BITS)), CW'(coef_q(RGB_MILLI[1], FRAC_BITS)),
		CW'(coef_q(RGB_MILLI[2], FRAC_BITS)), CW'(coef_q(RGB_MILLI[3], FRAC_BITS)),
		CW'(coef_q(RGB_MILLI[4], FRAC_BITS)), CW'(coef_q(RGB_MILLI[5], FRAC_BITS)),
		CW'(coef_q(RGB_MILLI[6], FRAC_BITS)), CW'(coef_q(RGB_MILLI[7], FRAC_BITS)),
		CW'(coef_q(RGB_MILLI[8], FRAC_BITS))
	};

	logic signed [ANGLE_W-1:0] cos_q;
	logic signed [ANGLE_W-1:0] sin_q;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	logic signed [YW-1:0] yiq_s1 [3];
	logic signed [YW-1:0] y_s2, y_s3;
	logic signed [PW-1:0] ci_s2, sq_s2, si_s2, cq_s2;
	logic signed [RW-1:0] i_s3, q_s3;
	logic signed [SW-1:0] prod_s4 [9];
	logic [CHAN_W-1:0]    chan_s5 [3];

	logic signed [YW-1:0] yiq_d [3];
	logic signed [PW-1:0] i_sum, q_sum;
	logic signed [SW-1:0] rgb_sum [3];
	logic signed [TW-1:0] rgb_flr [3];
	logic [CHAN_W-1:0]    chan_d [3];
	logic signed [SW-1:0] rot_ext [3];
	logic signed [YW-1:0] px_ext [3];

	assign rdy5 = !vld_s5 || m_axis_tready;
	assign rdy4 = !vld_s4 || rdy5;
	assign rdy3 = !vld_s3 || rdy4;
	assign rdy2 = !vld_s2 || rdy3;
	assign rdy1 = !vld_s1 || rdy2;

	assign s_axis_tready = rdy1;
	assign m_axis_tvalid = vld_s5;
	assign m_axis_tdata  = {chan_s5[2], chan_s5[1], chan_s5[0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q <= ANGLE_W'(1 << ANGLE_FRAC);
			sin_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COS_ANGLE: cos_q <= cfg_data;
				REG_SIN_ANGLE: sin_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= s_axis_tvalid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
			if (rdy4) vld_s4 <= vld_s3;
			if (rdy5) vld_s5 <= vld_s4;
		end
	end

	// RGB to YIQ with constant coefficients.
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			px_ext[c] = YW'($signed({1'b0, s_axis_tdata[c*CHAN_W +: CHAN_W]}));
		end
		for (int r = 0; r < 3; r++) begin
			yiq_d[r] = YW'(K_YIQ[r*3]) * px_ext[0]
				+ YW'(K_YIQ[r*3+1]) * px_ext[1]
				+ YW'(K_YIQ[r*3+2]) * px_ext[2];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			yiq_s1 <= yiq_d;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2) begin
			y_s2  <= yiq_s1[0];
			ci_s2 <= PW'(cos_q) * PW'(yiq_s1[1]);
			sq_s2 <= PW'(sin_q) * PW'(yiq_s1[2]);
			si_s2 <= PW'(sin_q) * PW'(yiq_s1[1]);
			cq_s2 <= PW'(cos_q) * PW'(yiq_s1[2]);
		end
	end

	// The arithmetic shift floors towards minus infinity.
	assign i_sum = ci_s2 - sq_s2;
	assign q_sum = si_s2 + cq_s2;

	always_ff @(posedge clk) begin
		if (rdy3) begin
			y_s3 <= y_s2;
			i_s3 <= i_sum[PW-1:ANGLE_FRAC];
			q_s3 <= q_sum[PW-1:ANGLE_FRAC];
		end
	end

	assign rot_ext[0] = SW'(y_s3);
	assign rot_ext[1] = SW'(i_s3);
	assign rot_ext[2] = SW'(q_s3);

	always_ff @(posedge clk) begin
		if (rdy4) begin
			for (int k = 0; k < 9; k++) begin
				prod_s4[k] <= SW'(K_RGB[k]) * rot_ext[k % 3];
			end
		end
	end

	// Sum, floor and clamp each channel into 0..255.
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			rgb_sum[r] = prod_s4[r*3] + prod_s4[r*3+1] + prod_s4[r*3+2];
			rgb_flr[r] = rgb_sum[r][SW-1:2*FRAC_BITS];
			if (rgb_flr[r][TW-1]) begin
				chan_d[r] = '0;
			end else if (|rgb_flr[r][TW-2:CHAN_W]) begin
				chan_d[r] = '1;
			end else begin
				chan_d[r] = rgb_flr[r][CHAN_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy5) begin
			chan_s5 <= chan_d;
		end
	end

endmodule

// ----- bench/tb.sv -----
// Self-checking testbench for the YIQ hue rotation pixel pipeline.
`timescale 1ns / 1ps

module tb;

	localparam int FRAC_BITS   = 14;
	localparam int ANGLE_FRAC  = 14;
	localparam int PHASE_BEATS = 100;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} rgb_pixel_t;

	class hue_rotation_checker;
		longint to_yiq [9];
		longint to_rgb [9];
		longint cos_q;
		longint sin_q;
		rgb_pixel_t pending_pixels [$];
		int mismatches;
		int matched;

		function new();
			to_yiq = '{4899, 9617, 1868, 9765, -4489, -5259, 3457, -8569, 5095};
			to_rgb = '{16384, 15663, 10174, 16384, -4456, -10600, 16384, -18137, 27935};
			cos_q = 16384;
			sin_q = 0;
			mismatches = 0;
			matched = 0;
		endfunction

		function void set_angle(logic idx, logic [yhr_pkg::ANGLE_W-1:0] val);
			case (idx)
				yhr_pkg::REG_COS_ANGLE: cos_q = longint'($signed(val));
				yhr_pkg::REG_SIN_ANGLE: sin_q = longint'($signed(val));
				default: ;
			endcase
		endfunction

		function rgb_pixel_t rotate_hue(rgb_pixel_t pix);
			longint ch [3];
			longint yiq [3];
			longint rot [3];
			longint sum;
			logic [7:0] chan [3];
			rgb_pixel_t res;
			ch[0] = pix.red;
			ch[1] = pix.green;
			ch[2] = pix.blue;
			for (int r = 0; r < 3; r++)
				yiq[r] = to_yiq[3*r] * ch[0] + to_yiq[3*r+1] * ch[1] + to_yiq[3*r+2] * ch[2];
			rot[0] = yiq[0];
			rot[1] = (cos_q * yiq[1] - sin_q * yiq[2]) >>> ANGLE_FRAC;
			rot[2] = (sin_q * yiq[1] + cos_q * yiq[2]) >>> ANGLE_FRAC;
			for (int r = 0; r < 3; r++) begin
				sum = (to_rgb[3*r] * rot[0] + to_rgb[3*r+1] * rot[1]
					+ to_rgb[3*r+2] * rot[2]) >>> FRAC_BITS;
				if (sum < 0)
					chan[r] = 8'd0;
				else if ((sum >>> FRAC_BITS) > 255)
					chan[r] = 8'd255;
				else
					chan[r] = 8'(sum >>> FRAC_BITS);
			end
			res.red   = chan[0];
			res.green = chan[1];
			res.blue  = chan[2];
			return res;
		endfunction

		function void note_pixel(rgb_pixel_t pix);
			pending_pixels.push_back(rotate_hue(pix));
		endfunction

		function int pending();
			return pending_pixels.size();
		endfunction

		function void check_pixel(rgb_pixel_t got);
			rgb_pixel_t want;
			if (pending_pixels.size() == 0) begin
				$error("Result beat %h arrived with no pixel outstanding.", got);
				mismatches++;
				return;
			end
			want = pending_pixels.pop_front();
			matched++;
			if (got.red !== want.red) begin
				$error("red_out: expected %0d, actual %0d", want.red, got.red);
				mismatches++;
			end
			if (got.green !== want.green) begin
				$error("green_out: expected %0d, actual %0d", want.green, got.green);
				mismatches++;
			end
			if (got.blue !== want.blue) begin
				$error("blue_out: expected %0d, actual %0d", want.blue, got.blue);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b1;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic cfg_we = 1'b0;
	logic cfg_index = yhr_pkg::REG_COS_ANGLE;
	logic [yhr_pkg::ANGLE_W-1:0] cfg_data = '0;

	hue_rotation_checker hue_check = new();
	bit src_idle = 1'b0;
	bit sink_idle = 1'b0;
	int pixels_sent = 0;
	int angle_settings = 1;
	int cycle_count = 0;

	yiq_hue_rotate_pixel #(.FRAC_BITS(FRAC_BITS)) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Run timed out after %0d cycles.", cycle_count);
			$display("yiq_hue_rotate_pixel verification failed");
			$finish;
		end
	end

	task automatic send_pixel(input rgb_pixel_t pix);
		int gap;
		gap = src_idle ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= pix;
		do @(posedge clk); while (!s_axis_tready);
		hue_check.note_pixel(pix);
		pixels_sent++;
	endtask

	task automatic drain_pipeline();
		s_axis_tvalid <= 1'b0;
		while (hue_check.pending() > 0) @(posedge clk);
	endtask

	task automatic write_angle(input logic idx, input logic [yhr_pkg::ANGLE_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		hue_check.set_angle(idx, val);
	endtask

	function automatic logic [7:0] random_channel();
		if ($urandom_range(0, 4) == 0)
			return $urandom_range(0, 1) ? 8'd255 : 8'd0;
		return 8'($urandom_range(0, 255));
	endfunction

	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = sink_idle ? $urandom_range(0, 9) : 0;
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			hue_check.check_pixel(m_axis_tdata);
		end
	end

	initial begin
		rgb_pixel_t corner [12];
		rgb_pixel_t pix;
		logic [15:0] cos_v;
		logic [15:0] sin_v;
		arst_n <= 1'b0;
		corner = '{
			'{8'd0,   8'd0,   8'd0},   '{8'd255, 8'd255, 8'd255},
			'{8'd0,   8'd0,   8'd255}, '{8'd0,   8'd255, 8'd0},
			'{8'd255, 8'd0,   8'd0},   '{8'd0,   8'd255, 8'd255},
			'{8'd255, 8'd255, 8'd0},   '{8'd255, 8'd0,   8'd255},
			'{8'd128, 8'd128, 8'd128}, '{8'd3,   8'd2,   8'd1},
			'{8'd170, 8'd85,  8'd170}, '{8'd85,  8'd170, 8'd85}
		};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (corner[k])
			send_pixel(corner[k]);

		for (int ph = 0; ph <= 10; ph++) begin
			drain_pipeline();
			if (ph > 0) begin
				case (ph)
					1:       begin cos_v = 16'hC000; sin_v = 16'h0000; end
					2:       begin cos_v = 16'h0000; sin_v = 16'h4000; end
					3:       begin cos_v = 16'h0000; sin_v = 16'hC000; end
					4:       begin cos_v = 16'd11585; sin_v = 16'd11585; end
					5:       begin cos_v = 16'h8000; sin_v = 16'h7FFF; end
					6:       begin cos_v = 16'h7FFF; sin_v = 16'h8000; end
					10:      begin cos_v = 16'h4000; sin_v = 16'h0000; end
					default: begin
						cos_v = 16'($urandom);
						sin_v = 16'($urandom);
					end
				endcase
				write_angle(yhr_pkg::REG_COS_ANGLE, cos_v);
				write_angle(yhr_pkg::REG_SIN_ANGLE, sin_v);
				angle_settings++;
			end
			src_idle  = (ph % 4 != 1) && ($urandom_range(0, 3) != 0);
			sink_idle = (ph % 4 != 2) && ($urandom_range(0, 3) != 0);
			for (int n = 0; n < PHASE_BEATS; n++) begin
				pix.red   = random_channel();
				pix.green = random_channel();
				pix.blue  = random_channel();
				send_pixel(pix);
			end
		end

		drain_pipeline();
		repeat (20) @(posedge clk);
		if (hue_check.pending() > 0) begin
			$error("%0d expected pixels never arrived.", hue_check.pending());
			hue_check.mismatches++;
		end
		$display("Sent %0d pixels across %0d angle settings, with and without idle beats.",
			pixels_sent, angle_settings);
		$display("Checked %0d result pixels, %0d field mismatches.",
			hue_check.matched, hue_check.mismatches);
		if (hue_check.mismatches == 0)
			$display("yiq_hue_rotate_pixel verification clean");
		else
			$display("yiq_hue_rotate_pixel verification failed");
		$finish;
	end

endmodule
